// ===== hw/rtl/psfc_pkg.sv =====
// Shared constants, codes and control/status structs for the prime sieve filter chain.
`default_nettype none

package psfc_pkg;

  // Parameter defaults.
  localparam int NUM_CELLS_DEF  = 16;
  localparam int VALUE_BITS_DEF = 16;

  // Fixed field widths on the stream ports.
  localparam int CAND_W    = 16;
  localparam int VERDICT_W = 2;
  localparam int INDEX_W   = 4;
  localparam int OUT_W     = 24;  // 22 payload bits padded to whole bytes

  // Smallest number that takes part in the sieve.
  localparam int MIN_CANDIDATE = 2;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_PRIME    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_MULTIPLE = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_OVERFLOW = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load;         // take a new candidate, restart the walk
    logic                 capture;      // store candidate in the next free cell
    logic                 div_start;    // clear the remainder, start at the top bit
    logic                 div_step;     // one restoring remainder step
    logic                 next_cell;    // advance the walk to the following cell
    logic                 set_verdict;  // record verdict and cell index
    logic [VERDICT_W-1:0] verdict;
    logic                 index_zero;   // report cell index 0 instead of the walk
    logic                 emit;         // load the output register
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;   // candidate is 0 or 1
    logic at_fill;     // walk has reached the first unused cell
    logic at_end;      // walk has passed the last cell
    logic div_last;    // current remainder step is the final one
    logic rem_zero;    // remainder after the last step is zero
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psfc_datapath.sv =====
// Datapath: candidate register, cell prime memory, fill count, remainder unit, output register.
`default_nettype none

module psfc_datapath
  import psfc_pkg::*;
#(
  parameter int NUM_CELLS  = NUM_CELLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CAND_W-1:0] s_tdata,
  input  wire logic              s_tlast,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata,
  output logic                   m_tlast,
  input  wire ctrl_t             ctrl,
  output status_t                status
);

  localparam int CNT_W = $clog2(NUM_CELLS + 1);
  localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int BIT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] cell_mem [NUM_CELLS];
  logic [VALUE_BITS-1:0] prime_q;

  logic [VALUE_BITS-1:0] cand;
  logic                  last_q;
  logic [CNT_W-1:0]      walk;
  logic [CNT_W-1:0]      fill;
  logic [VALUE_BITS-1:0] rem;
  logic [BIT_W-1:0]      bitcnt;
  logic [VERDICT_W-1:0]  res_verdict;
  logic [INDEX_W-1:0]    res_index;

  logic [VALUE_BITS:0]   rem_shift;
  logic [VALUE_BITS:0]   rem_sub;
  logic [VALUE_BITS-1:0] rem_next;

  // Restoring remainder step: bring in one candidate bit, subtract if it fits.
  assign rem_shift = {rem, cand[bitcnt]};
  assign rem_sub   = rem_shift - {1'b0, prime_q};
  assign rem_next  = rem_sub[VALUE_BITS] ? rem_shift[VALUE_BITS-1:0]
                                         : rem_sub[VALUE_BITS-1:0];

  assign status.below_two = (cand < VALUE_BITS'(MIN_CANDIDATE));
  assign status.at_fill   = (walk == fill);
  assign status.at_end    = (walk == CNT_W'(NUM_CELLS));
  assign status.div_last  = (bitcnt == '0);
  assign status.rem_zero  = (rem == '0);
  assign status.out_free  = !m_tvalid || m_tready;

  // Cell memory: one write port at the fill point, one registered read at the walk.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cell_mem[fill[IDX_W-1:0]] <= cand;
    end
    prime_q <= cell_mem[walk[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cand   <= VALUE_BITS'(s_tdata);
      last_q <= s_tlast;
    end
    if (ctrl.div_start) begin
      rem    <= '0;
      bitcnt <= BIT_W'(VALUE_BITS - 1);
    end else if (ctrl.div_step) begin
      rem    <= rem_next;
      bitcnt <= bitcnt - 1'b1;
    end
    if (ctrl.set_verdict) begin
      res_verdict <= ctrl.verdict;
      res_index   <= ctrl.index_zero ? '0 : INDEX_W'(walk);
    end
    if (ctrl.emit) begin
      m_tdata <= {2'b00, res_index, res_verdict, CAND_W'(cand)};
      m_tlast <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk     <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctrl.load) begin
        walk <= '0;
      end else if (ctrl.next_cell) begin
        walk <= walk + 1'b1;
      end
      if (ctrl.emit && last_q) begin
        fill <= '0;
      end else if (ctrl.capture) begin
        fill <= fill + 1'b1;
      end
      if (ctrl.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/psfc_ctrl.sv =====
// Controller state machine that walks one candidate through the filter cells.
`default_nettype none

module psfc_ctrl
  import psfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  input  wire status_t status,
  output ctrl_t        ctrl
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_TEST  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ctrl.load  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.below_two) begin
          ctrl.set_verdict = 1'b1;
          ctrl.verdict     = VERDICT_MULTIPLE;
          ctrl.index_zero  = 1'b1;
          state_next       = ST_DONE;
        end else if (status.at_end) begin
          ctrl.set_verdict = 1'b1;
          ctrl.verdict     = VERDICT_OVERFLOW;
          ctrl.index_zero  = 1'b1;
          state_next       = ST_DONE;
        end else if (status.at_fill) begin
          ctrl.capture     = 1'b1;
          ctrl.set_verdict = 1'b1;
          ctrl.verdict     = VERDICT_PRIME;
          state_next       = ST_DONE;
        end else begin
          ctrl.div_start = 1'b1;
          state_next     = ST_DIV;
        end
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          ctrl.set_verdict = 1'b1;
          ctrl.verdict     = VERDICT_MULTIPLE;
          state_next       = ST_DONE;
        end else begin
          ctrl.next_cell = 1'b1;
          state_next     = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          ctrl.emit  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/prime_sieve_filter_chain.sv =====
// Top level of the prime sieve filter chain: controller plus datapath.
//
//   Channel   Direction  Payload
//   s_*       in         tdata[15:0] candidate, tlast end_of_stream
//   m_*       out        tdata[15:0] number_out, [17:16] verdict, [21:18] cell_index,
//                        [23:22] zero; tlast last_out
//
// Each transaction on s_* yields exactly one transaction on m_*. The candidate is
// walked cell by cell and tested against the used cells in turn in the shared
// restoring remainder unit, which retires one bit per cycle. It is captured as a prime
// at the first unused cell, removed as a multiple at the first cell that leaves a zero
// remainder, reported as an overflow when all cells are used and none divides it, and
// reported as a multiple without any cell test when it is below two; s_tready rises
// again in the cycle after the result is loaded. Reset clears the state machine, the
// fill count and the output valid; the cell memory needs no clearing because only
// cells below the fill count are ever used as divisors. A new candidate is taken
// while a result is still waiting on m_*; it then stalls only at its own hand-off
// until the output register drains.
`default_nettype none

module prime_sieve_filter_chain
  import psfc_pkg::*;
#(
  parameter int NUM_CELLS  = NUM_CELLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [CAND_W-1:0] s_tdata,   // [15:0] candidate
  input  wire logic              s_tlast,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // [15:0] number_out, [17:16] verdict,
                                            // [21:18] cell_index, [23:22] zero
  output logic                   m_tlast
);

  ctrl_t   ctrl;
  status_t status;

  // The controller sequences each cell test; the datapath holds all data storage.
  psfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  psfc_datapath #(
    .NUM_CELLS  (NUM_CELLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .ctrl     (ctrl),
    .status   (status)
  );

  // One candidate is in work at a time: acceptance closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a candidate was still in work");

  // A result is only loaded when the output register is free to take it.
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over one not yet taken");

  // No undefined verdict code ever reaches the output.
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:16] != 2'd3))
    else $error("undefined verdict code on output");

  // Overflow always reports cell index zero.
  a_overflow_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[17:16] == VERDICT_OVERFLOW) |-> (m_tdata[21:18] == '0))
    else $error("overflow verdict with nonzero cell index");

endmodule

`default_nettype wire
